### src/event_flag_table_defines.svh
// Assertion macros used by the checker file.
`ifndef EVENT_FLAG_TABLE_DEFINES_SVH
`define EVENT_FLAG_TABLE_DEFINES_SVH
// Antecedent implies consequent on the same edge.
`define EFT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent on the next edge.
`define EFT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### src/eft_pkg.sv
// Package with the types, codes and constants of the event flag table.
package eft_pkg;
  localparam int SLOTS_DEF = 32;
  localparam int LIST_MAX_DEF = 32;
  localparam int HANDLE_BITS_DEF = 32;
  localparam logic [63:0] FIRST_HANDLE = 64'h1234000;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0, ACT_SET = 3'd1, ACT_RESET = 3'd2, ACT_CLOSE = 3'd3,
    ACT_WAIT = 3'd4, ACT_WAIT_LIST = 3'd5, ACT_RSV6 = 3'd6, ACT_RSV7 = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_NOT_FOUND = 3'd1, ST_NOT_EVENT = 3'd2, ST_FULL = 3'd3,
    ST_INVALID = 3'd4, ST_NOT_READY = 3'd5, ST_RSV6 = 3'd6, ST_RSV7 = 3'd7
  } status_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] handle;
    logic        keep_flag;
    logic        start_flag;
    logic        need_all;
    logic        last_in_list;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] handle_out;
    logic [4:0]  signaled_position;
  } rsp_t;
endpackage

### src/eft_front.sv
// Front end: takes input items, drops reserved actions and queues the rest.
module eft_front #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  eft_pkg::cmd_t in_cmd,
  output logic          q_valid,
  input  logic          q_pop,
  output eft_pkg::cmd_t q_cmd
);
  import eft_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0] cnt_r, cnt_nxt;
  logic push, take;

  assign in_stall = (cnt_r == (AW+1)'(DEPTH));
  assign take = in_valid && !in_stall;
  assign push = take && (in_cmd.action != ACT_RSV6) && (in_cmd.action != ACT_RSV7);
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push) wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (q_pop) rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) mem_r[wp_r] <= in_cmd;
  end
endmodule

### src/eft_back.sv
// Back end: slot table, handle counter and wait list evaluation.
module eft_back #(
  parameter int SLOTS = 32,
  parameter int LIST_MAX = 32,
  parameter int HANDLE_BITS = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_pop,
  input  eft_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_stall,
  output eft_pkg::rsp_t out_rsp
);
  import eft_pkg::*;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int HB = HANDLE_BITS;
  localparam logic [HB-1:0] HMAX = '1;

  logic [HB-1:0] slot_handle_r [SLOTS];
  logic [SLOTS-1:0] ev_r, ev_nxt, man_r, man_nxt, sig_r, sig_nxt, clr_r, clr_nxt;
  logic [HB-1:0] next_r, next_nxt;
  logic [6:0] lpos_r, lpos_nxt;
  status_t lerr_r, lerr_nxt;
  logic any_r, any_nxt, all_r, all_nxt;
  logic [4:0] apos_r, apos_nxt;
  logic [SW-1:0] aslot_r, aslot_nxt;
  logic ov_r, ov_nxt;
  rsp_t rsp_r, rsp_nxt;

  logic hw_en;
  logic [SW-1:0] hw_idx;
  logic [HB-1:0] hw_val;

  logic [HB-1:0] h;
  logic [SLOTS-1:0] hit, freev;
  logic found, freef;
  logic [SW-1:0] hs, fs;
  status_t chk;
  logic go;

  assign h = HB'(q_cmd.handle);
  assign q_pop = q_valid && (!ov_r || !out_stall);
  assign go = q_pop;
  assign out_valid = ov_r;
  assign out_rsp = rsp_r;

  always_comb begin
    found = 1'b0; hs = '0; freef = 1'b0; fs = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit[i] = (h != '0) && (slot_handle_r[i] == h);
      freev[i] = (slot_handle_r[i] == '0);
    end
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit[i]) begin found = 1'b1; hs = SW'(i); end
      if (freev[i]) begin freef = 1'b1; fs = SW'(i); end
    end
    chk = !found ? ST_NOT_FOUND : (!ev_r[hs] ? ST_NOT_EVENT : ST_OK);
  end

  always_comb begin
    ev_nxt = ev_r; man_nxt = man_r; sig_nxt = sig_r; clr_nxt = clr_r;
    next_nxt = next_r;
    lpos_nxt = lpos_r; lerr_nxt = lerr_r; any_nxt = any_r; all_nxt = all_r;
    apos_nxt = apos_r; aslot_nxt = aslot_r;
    ov_nxt = ov_r && out_stall;
    rsp_nxt = rsp_r;
    hw_en = 1'b0; hw_idx = hs; hw_val = '0;
    if (go) begin
      rsp_nxt = '{status: ST_OK, handle_out: '0, signaled_position: '0};
      ov_nxt = 1'b1;
      case (q_cmd.action)
        ACT_CREATE: begin
          next_nxt = next_r + 1'b1;
          if (next_r == '0 || next_r == HMAX) rsp_nxt.status = ST_INVALID;
          else if (!freef) rsp_nxt.status = ST_FULL;
          else begin
            hw_en = 1'b1; hw_idx = fs; hw_val = next_r;
            ev_nxt[fs] = 1'b1;
            man_nxt[fs] = q_cmd.keep_flag;
            sig_nxt[fs] = q_cmd.start_flag;
            rsp_nxt.handle_out = 32'(next_r);
          end
        end
        ACT_SET, ACT_RESET: begin
          rsp_nxt.status = chk;
          if (chk == ST_OK) sig_nxt[hs] = (q_cmd.action == ACT_SET);
        end
        ACT_CLOSE: begin
          if (!found) rsp_nxt.status = ST_NOT_FOUND;
          else begin
            hw_en = 1'b1; hw_idx = hs; hw_val = '0;
            ev_nxt[hs] = 1'b0; man_nxt[hs] = 1'b0; sig_nxt[hs] = 1'b0;
          end
        end
        ACT_WAIT: begin
          rsp_nxt.status = chk;
          if (chk == ST_OK) begin
            if (!sig_r[hs]) rsp_nxt.status = ST_NOT_READY;
            else if (!man_r[hs]) sig_nxt[hs] = 1'b0;
          end
        end
        ACT_WAIT_LIST: begin
          // Fold this element into the running list state first.
          if (lpos_r < 7'(LIST_MAX)) begin
            lpos_nxt = lpos_r + 7'd1;
            if (chk != ST_OK) begin
              if (lerr_r == ST_OK) lerr_nxt = chk;
            end else if (sig_r[hs]) begin
              if (!any_r) begin
                any_nxt = 1'b1; apos_nxt = lpos_r[4:0]; aslot_nxt = hs;
              end
              clr_nxt[hs] = 1'b1;
            end else all_nxt = 1'b0;
          end
          if (!q_cmd.last_in_list) begin
            ov_nxt = 1'b0;
          end else begin
            if (lerr_nxt != ST_OK) rsp_nxt.status = lerr_nxt;
            else if (q_cmd.need_all) begin
              if (all_nxt) sig_nxt = sig_r & ~(clr_nxt & ~man_r);
              else rsp_nxt.status = ST_NOT_READY;
            end else if (any_nxt) begin
              if (!man_r[aslot_nxt]) sig_nxt[aslot_nxt] = 1'b0;
              rsp_nxt.signaled_position = apos_nxt;
            end else rsp_nxt.status = ST_NOT_READY;
            lpos_nxt = '0; lerr_nxt = ST_OK; any_nxt = 1'b0; all_nxt = 1'b1;
            apos_nxt = '0; aslot_nxt = '0; clr_nxt = '0;
          end
        end
        default: ov_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) slot_handle_r[i] <= '0;
      ev_r <= '0; man_r <= '0; sig_r <= '0; clr_r <= '0;
      next_r <= HB'(FIRST_HANDLE);
      lpos_r <= '0; lerr_r <= ST_OK; any_r <= 1'b0; all_r <= 1'b1;
      apos_r <= '0; aslot_r <= '0; ov_r <= 1'b0;
      rsp_r <= '{status: ST_OK, handle_out: '0, signaled_position: '0};
    end else begin
      if (hw_en) slot_handle_r[hw_idx] <= hw_val;
      ev_r <= ev_nxt; man_r <= man_nxt; sig_r <= sig_nxt; clr_r <= clr_nxt;
      next_r <= next_nxt;
      lpos_r <= lpos_nxt; lerr_r <= lerr_nxt; any_r <= any_nxt; all_r <= all_nxt;
      apos_r <= apos_nxt; aslot_r <= aslot_nxt; ov_r <= ov_nxt;
      rsp_r <= rsp_nxt;
    end
  end
endmodule

### src/event_flag_table.sv
// Top level of the event flag table.
// Items enter on in_* under in_valid/in_stall and results leave on out_*
// under out_valid/out_stall. Create, set, reset, close and a single wait
// each give one result; a wait list element gives one only when it is
// marked last. Reserved actions are dropped at the front and give nothing.
// A two-entry queue sits between the front and the back; the back looks up
// the handle across all slots combinationally. An accepted item is written
// into the queue, and its result is registered in the output register of
// the back, which drives out_valid.
// One item is served per cycle while the output register is free or taken.
// When out_stall is held, the output register and then the queue fill and
// in_stall rises; nothing is lost. Synchronous reset frees every slot,
// sets the handle counter to 0x1234000 and clears any open wait list.
module event_flag_table #(
  parameter int SLOTS = eft_pkg::SLOTS_DEF,
  parameter int LIST_MAX = eft_pkg::LIST_MAX_DEF,
  parameter int HANDLE_BITS = eft_pkg::HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [31:0] in_handle,
  input  logic        in_keep_flag,
  input  logic        in_start_flag,
  input  logic        in_need_all,
  input  logic        in_last_in_list,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_handle_out,
  output logic [4:0]  out_signaled_position
);
  import eft_pkg::*;

  cmd_t in_cmd, q_cmd;
  rsp_t rsp;
  logic q_valid, q_pop;

  always_comb begin
    in_cmd.action = action_t'(in_action);
    in_cmd.handle = in_handle;
    in_cmd.keep_flag = in_keep_flag;
    in_cmd.start_flag = in_start_flag;
    in_cmd.need_all = in_need_all;
    in_cmd.last_in_list = in_last_in_list;
  end

  eft_front #(.DEPTH(2)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd,
    .q_valid, .q_pop, .q_cmd
  );

  eft_back #(.SLOTS(SLOTS), .LIST_MAX(LIST_MAX), .HANDLE_BITS(HANDLE_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_cmd,
    .out_valid, .out_stall, .out_rsp(rsp)
  );

  assign out_status = rsp.status;
  assign out_handle_out = rsp.handle_out;
  assign out_signaled_position = rsp.signaled_position;
endmodule

### src/eft_checker.sv
// Port checker for the event flag table and its bind.
`include "event_flag_table_defines.svh"
module eft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_handle_out,
  input logic [4:0]  out_signaled_position
);
  import eft_pkg::*;

  `EFT_ASSERT_NXT(a_out_hold, out_valid && out_stall,
                  out_valid && $stable(out_handle_out), "held result changed")
  `EFT_ASSERT_IMP(a_hout_ok, out_valid && out_handle_out != 32'd0,
                  out_status == ST_OK, "handle returned with error")
  `EFT_ASSERT_IMP(a_pos_ok, out_valid && out_signaled_position != 5'd0,
                  out_status == ST_OK && out_handle_out == 32'd0, "position with error")
  `EFT_ASSERT_IMP(a_status_rng, out_valid, out_status <= ST_NOT_READY, "bad status code")
endmodule

bind event_flag_table eft_checker u_eft_checker (
  .clk, .rst_n, .out_valid, .out_stall,
  .out_status, .out_handle_out, .out_signaled_position
);
